>>> rtl/core/fiwm_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fiwm_pkg
// Shared types and constants for the frame interval window monitor.
// ----------------------------------------------------------------------------
package fiwm_pkg;

  localparam int TIME_W    = 64;
  localparam int COUNT_W   = 32;
  localparam int SECONDS_W = 16;
  localparam int RATE_W    = 32;

  // Window threshold in ns: 65535 * 10^9 fits in 46 bits.
  localparam int THRESH_W  = 46;
  localparam logic [29:0] NS_PER_SECOND = 30'd1000000000;

  // 10^12 split into two 32-bit halves for the shared multiplier.
  localparam logic [31:0] PICO_LO = 32'd3567587328;
  localparam logic [31:0] PICO_HI = 32'd232;

  // Dividend count * 10^12 needs at most 32 + 40 bits.
  localparam int NUM_W     = 72;
  localparam int STEP_W    = $clog2(NUM_W);
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(NUM_W - 1);

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_START,
    S_RATE,
    S_EMIT
  } ctl_state_t;

  typedef enum logic [2:0] {
    R_IDLE,
    R_MUL_LO,
    R_MUL_HI,
    R_ADD,
    R_DIV,
    R_DONE
  } rate_state_t;

  typedef struct packed {
    logic               start;
    logic [COUNT_W-1:0] count;
    logic [TIME_W-1:0]  elapsed;
  } rate_cmd_t;

  typedef struct packed {
    logic              done;
    logic [RATE_W-1:0] rate;
  } rate_rsp_t;

endpackage
`default_nettype wire

>>> rtl/core/fiwm_rate_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fiwm_rate_unit
// Iterative rate unit: count * 10^12 through one shared 32x32 multiplier,
// then a one-bit-per-cycle restoring divide by the elapsed time, saturated.
// ----------------------------------------------------------------------------
module fiwm_rate_unit
  import fiwm_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire rate_cmd_t cmd,
  output rate_rsp_t      rsp
);

  rate_state_t state, state_next;

  logic [COUNT_W-1:0] count_q;
  logic [TIME_W-1:0]  divisor;
  logic [TIME_W-1:0]  prod;
  logic [NUM_W-1:0]   num;
  logic [TIME_W-1:0]  rem;
  logic [STEP_W-1:0]  step;

  logic [31:0]        mul_k;
  logic [TIME_W-1:0]  mul_p;
  logic [TIME_W:0]    rem_sh;
  logic [TIME_W:0]    rem_sub;
  logic               ge;

  // Shared multiplier: constant half picked by the sequencer.
  assign mul_k = (state == R_MUL_HI) ? PICO_HI : PICO_LO;
  assign mul_p = TIME_W'(count_q) * TIME_W'(mul_k);

  // One restoring divide step.
  assign rem_sh  = {rem, num[NUM_W-1]};
  assign rem_sub = rem_sh - {1'b0, divisor};
  assign ge      = (rem_sh >= {1'b0, divisor});

  always_comb begin
    state_next = state;
    unique case (state)
      R_IDLE:   if (cmd.start) state_next = R_MUL_LO;
      R_MUL_LO: state_next = R_MUL_HI;
      R_MUL_HI: state_next = R_ADD;
      R_ADD:    state_next = R_DIV;
      R_DIV:    if (step == LAST_STEP) state_next = R_DONE;
      R_DONE:   state_next = R_IDLE;
      default:  state_next = R_IDLE;
    endcase
  end

  // Quotient bits above 32 mean saturation.
  always_comb begin
    rsp.done = (state == R_DONE);
    rsp.rate = (|num[NUM_W-1:RATE_W]) ? COUNT_MAX : num[RATE_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= R_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      R_IDLE: begin
        if (cmd.start) begin
          count_q <= cmd.count;
          divisor <= cmd.elapsed;
        end
      end
      R_MUL_LO: prod <= mul_p;
      R_MUL_HI: begin
        num  <= {{(NUM_W-TIME_W){1'b0}}, prod};
        prod <= mul_p;
      end
      R_ADD: begin
        num  <= num + {prod[NUM_W-COUNT_W-1:0], {COUNT_W{1'b0}}};
        rem  <= '0;
        step <= '0;
      end
      R_DIV: begin
        rem  <= ge ? rem_sub[TIME_W-1:0] : rem_sh[TIME_W-1:0];
        num  <= {num[NUM_W-2:0], ge};
        step <= step + 1'b1;
      end
      default: ;
    endcase
  end

endmodule
`default_nettype wire

>>> rtl/core/frame_interval_window_monitor.sv
`default_nettype none
// ----------------------------------------------------------------------------
// frame_interval_window_monitor
// Measures frame intervals over an armed window and reports count, shortest
// and longest interval, and frames per second in thousandths.
// ----------------------------------------------------------------------------
//
//  channel  signals                                        transfer when
//  -------  ---------------------------------------------  --------------------
//  in       in_valid, in_stall, action, timestamp_ns,      in_valid & !in_stall
//           window_seconds
//  out      out_valid, out_stall, frames_per_second_milli, out_valid & !out_stall
//           shortest_interval_ns, longest_interval_ns,
//           frames_in_window
//
// Steps: an arm item or a frame that does not end a window is captured, then
// evaluated. A frame that ends the window also runs the shared rate unit: a low
// multiply, a high multiply, an add, and then 72 restoring divide steps.
// Reset (rst, synchronous) closes the window, drops any request and empties
// the output register. in_stall stays high during reset and while an item is
// in work; a result waiting in the output register does not block arm items
// or frames that produce no result.
// ----------------------------------------------------------------------------
module frame_interval_window_monitor
  import fiwm_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic                 action,
  input  wire logic [TIME_W-1:0]    timestamp_ns,
  input  wire logic [SECONDS_W-1:0] window_seconds,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic [RATE_W-1:0]         frames_per_second_milli,
  output logic [TIME_W-1:0]         shortest_interval_ns,
  output logic [TIME_W-1:0]         longest_interval_ns,
  output logic [COUNT_W-1:0]        frames_in_window
);

  ctl_state_t state, state_next;

  // Captured input item.
  logic                 act_q;
  logic [TIME_W-1:0]    ts_q;
  logic [SECONDS_W-1:0] win_q;

  // Window state. The request is kept already scaled to ns; zero means none.
  logic                 seen_previous;
  logic [TIME_W-1:0]    previous_time;
  logic [TIME_W-1:0]    window_start;
  logic [THRESH_W-1:0]  pending_ns;
  logic [COUNT_W-1:0]   interval_count;
  logic [TIME_W-1:0]    interval_min;
  logic [TIME_W-1:0]    interval_max;
  logic [TIME_W-1:0]    elapsed_q;
  logic [RATE_W-1:0]    rate_q;

  logic [TIME_W-1:0]    interval;
  logic [TIME_W-1:0]    elapsed;
  logic                 window_open;
  logic                 window_ends;

  logic                 in_xfer;
  logic                 out_free;
  logic                 load_out;

  rate_cmd_t            rate_cmd;
  rate_rsp_t            rate_rsp;

  assign in_xfer     = in_valid && !in_stall;
  assign out_free    = !out_valid || !out_stall;

  // Intervals and elapsed time wrap modulo 2^64 when time runs backwards.
  assign interval    = ts_q - previous_time;
  assign elapsed     = ts_q - window_start;
  assign window_open = (window_start != '0);
  assign window_ends = (elapsed >= {{(TIME_W-THRESH_W){1'b0}}, pending_ns});

  // ---- next state --------------------------------------------------------
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (in_xfer) state_next = S_EXEC;
      S_EXEC: begin
        state_next = S_IDLE;
        if (!act_q && window_open && seen_previous && window_ends) begin
          state_next = S_START;
        end
      end
      S_START: state_next = S_RATE;
      S_RATE:  if (rate_rsp.done) state_next = S_EMIT;
      S_EMIT:  if (out_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // ---- control outputs ---------------------------------------------------
  always_comb begin
    in_stall          = (state != S_IDLE) || rst;
    load_out          = (state == S_EMIT) && out_free;
    rate_cmd.start    = (state == S_START);
    rate_cmd.count    = interval_count;
    rate_cmd.elapsed  = elapsed_q;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Capture the item on transfer.
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      act_q <= action;
      ts_q  <= timestamp_ns;
      win_q <= window_seconds;
    end
  end

  // ---- window tracking ---------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      seen_previous  <= 1'b0;
      previous_time  <= '0;
      window_start   <= '0;
      pending_ns     <= '0;
      interval_count <= '0;
      interval_min   <= '1;
      interval_max   <= '0;
    end else if (state == S_EXEC) begin
      if (act_q) begin
        // Arm: store the request, scaled to ns.
        pending_ns <= THRESH_W'(win_q) * THRESH_W'(NS_PER_SECOND);
      end else begin
        previous_time <= ts_q;
        seen_previous <= 1'b1;
        if (!window_open) begin
          // Open on a pending request; a frame at time zero leaves it closed.
          if (pending_ns != '0) begin
            window_start   <= ts_q;
            interval_count <= '0;
            interval_min   <= '1;
            interval_max   <= '0;
          end
        end else if (seen_previous) begin
          if (interval < interval_min) interval_min <= interval;
          if (interval > interval_max) interval_max <= interval;
          if (interval_count != COUNT_MAX) interval_count <= interval_count + 1'b1;
          if (window_ends) begin
            // Close the window and drop the request; the result follows.
            window_start <= '0;
            pending_ns   <= '0;
          end
        end
      end
    end
  end

  // Hold the elapsed time and rate for the result.
  always_ff @(posedge clk) begin
    if (state == S_EXEC) elapsed_q <= elapsed;
    if (rate_rsp.done)   rate_q    <= rate_rsp.rate;
  end

  // ---- output register ---------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      frames_per_second_milli <= rate_q;
      shortest_interval_ns    <= interval_min;
      longest_interval_ns     <= interval_max;
      frames_in_window        <= interval_count;
    end
  end

  fiwm_rate_unit u_rate (
    .clk (clk),
    .rst (rst),
    .cmd (rate_cmd),
    .rsp (rate_rsp)
  );

endmodule
`default_nettype wire

>>> bench/tb_frame_interval_window_monitor.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tb_frame_interval_window_monitor
// Self-checking bench for the frame interval window monitor. A scoreboard
// class tracks the window state on every accepted transfer, computes the
// expected report (count, shortest and longest interval, rate in thousandths)
// and checks each report that leaves the block in order. A directed set of
// corner cases runs first, then random armed windows mixed with stray frames,
// stray arms and abandoned windows, with random gaps and stalls on both sides.
// ----------------------------------------------------------------------------
module tb_frame_interval_window_monitor;
  import fiwm_pkg::*;

  localparam logic ACT_FRAME = 1'b0;
  localparam logic ACT_ARM   = 1'b1;

  localparam int TOTAL_ITEMS  = 1550;
  localparam int LONG_HOLD    = 300;
  localparam int DRAIN_CYCLES = 100;
  // Longest quiet stretch in a correct run: a long hold plus one rate
  // computation plus both sides' gaps; take it several times over.
  localparam int QUIET_LIMIT  = 2000;

  localparam logic [127:0] MILLI_SCALE = 128'd1000000000000;
  localparam logic [63:0]  NS_PER_S    = 64'(NS_PER_SECOND);

  typedef struct {
    logic [RATE_W-1:0]  rate;
    logic [TIME_W-1:0]  shortest;
    logic [TIME_W-1:0]  longest;
    logic [COUNT_W-1:0] frames;
  } window_report_t;

  // Scoreboard: own copy of the window state plus the reports still owed.
  class window_tracker;
    bit                   seen_frame;
    logic [TIME_W-1:0]    last_stamp;
    logic [TIME_W-1:0]    opened_at;
    logic [SECONDS_W-1:0] armed_secs;
    logic [COUNT_W-1:0]   gap_count;
    logic [TIME_W-1:0]    gap_min;
    logic [TIME_W-1:0]    gap_max;
    window_report_t       owed_reports[$];
    int                   errors;

    function new();
      seen_frame = 1'b0;
      last_stamp = '0;
      opened_at  = '0;
      armed_secs = '0;
      gap_count  = '0;
      gap_min    = '1;
      gap_max    = '0;
      errors     = 0;
    endfunction

    // floor(frames * 10^12 / span), saturated; a zero span saturates too
    function logic [RATE_W-1:0] milli_rate(logic [COUNT_W-1:0] frames,
                                           logic [TIME_W-1:0] span);
      logic [127:0] scaled;
      logic [127:0] quot;
      if (span == '0) return '1;
      scaled = {96'd0, frames} * MILLI_SCALE;
      quot   = scaled / {64'd0, span};
      if (quot > 128'hFFFF_FFFF) return '1;
      return quot[RATE_W-1:0];
    endfunction

    function void take_item(logic act, logic [TIME_W-1:0] stamp,
                            logic [SECONDS_W-1:0] secs);
      logic [TIME_W-1:0] prior;
      logic [TIME_W-1:0] gap;
      logic [TIME_W-1:0] span;
      bit                had_prior;
      window_report_t    rep;
      if (act == ACT_ARM) begin
        armed_secs = secs;
        return;
      end
      prior      = last_stamp;
      had_prior  = seen_frame;
      last_stamp = stamp;
      seen_frame = 1'b1;
      // a closed window opens on a pending request; stamp zero keeps it closed
      if (opened_at == '0) begin
        if (armed_secs != '0) begin
          opened_at = stamp;
          gap_count = '0;
          gap_min   = '1;
          gap_max   = '0;
        end
        return;
      end
      if (!had_prior) return;
      gap = stamp - prior;
      if (gap < gap_min) gap_min = gap;
      if (gap > gap_max) gap_max = gap;
      if (gap_count != COUNT_MAX) gap_count++;
      span = stamp - opened_at;
      if (span < 64'(armed_secs) * NS_PER_S) return;
      rep.rate     = milli_rate(gap_count, span);
      rep.shortest = gap_min;
      rep.longest  = gap_max;
      rep.frames   = gap_count;
      owed_reports.push_back(rep);
      opened_at  = '0;
      armed_secs = '0;
    endfunction

    function void compare_field(string label, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
        errors++;
        $display("%0t: %s expected %0d got %0d", $time, label, want, got);
      end
    endfunction

    function void match_report(logic [RATE_W-1:0] rate, logic [TIME_W-1:0] shortest,
                               logic [TIME_W-1:0] longest, logic [COUNT_W-1:0] frames);
      window_report_t want;
      if (owed_reports.size() == 0) begin
        errors++;
        $display("%0t: report with none expected: rate %0d frames %0d", $time, rate,
                 frames);
        return;
      end
      want = owed_reports.pop_front();
      compare_field("frames_per_second_milli", 64'(want.rate), 64'(rate));
      compare_field("shortest_interval_ns", want.shortest, shortest);
      compare_field("longest_interval_ns", want.longest, longest);
      compare_field("frames_in_window", 64'(want.frames), 64'(frames));
    endfunction

    function int outstanding();
      return owed_reports.size();
    endfunction
  endclass

  logic                 clk = 1'b0;
  logic                 rst;
  logic                 in_valid;
  logic                 in_stall;
  logic                 action;
  logic [TIME_W-1:0]    timestamp_ns;
  logic [SECONDS_W-1:0] window_seconds;
  logic                 out_valid;
  logic                 out_stall;
  logic [RATE_W-1:0]    frames_per_second_milli;
  logic [TIME_W-1:0]    shortest_interval_ns;
  logic [TIME_W-1:0]    longest_interval_ns;
  logic [COUNT_W-1:0]   frames_in_window;

  window_tracker     tracker;
  int                items_sent;
  int                quiet_cycles;
  bit                steady;
  logic [TIME_W-1:0] now_ns;

  frame_interval_window_monitor dut (
    .clk                     (clk),
    .rst                     (rst),
    .in_valid                (in_valid),
    .in_stall                (in_stall),
    .action                  (action),
    .timestamp_ns            (timestamp_ns),
    .window_seconds          (window_seconds),
    .out_valid               (out_valid),
    .out_stall               (out_stall),
    .frames_per_second_milli (frames_per_second_milli),
    .shortest_interval_ns    (shortest_interval_ns),
    .longest_interval_ns     (longest_interval_ns),
    .frames_in_window        (frames_in_window)
  );

  always #5 clk = ~clk;

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // Offer one transfer after a random gap and hold it until the block takes it.
  // Lower valid only when a gap follows, so a back-to-back item keeps it high.
  task automatic send_item(logic act, logic [TIME_W-1:0] stamp,
                           logic [SECONDS_W-1:0] secs);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    action         <= act;
    timestamp_ns   <= stamp;
    window_seconds <= secs;
    do @(posedge clk); while (in_stall);
    items_sent++;
  endtask

  // Fill the ignored field with noise so its bits toggle too.
  task automatic send_frame(logic [TIME_W-1:0] stamp);
    send_item(ACT_FRAME, stamp, SECONDS_W'($urandom));
  endtask

  task automatic send_arm(logic [SECONDS_W-1:0] secs);
    send_item(ACT_ARM, rand64(), secs);
  endtask

  // Well-formed window: arm, open, a few frames inside, then one that closes it.
  task automatic run_window();
    logic [SECONDS_W-1:0] secs;
    logic [TIME_W-1:0]    span;
    logic [TIME_W-1:0]    start;
    logic [TIME_W-1:0]    stride;
    logic [TIME_W-1:0]    stamp;
    int                   inner;
    secs   = ($urandom_range(0, 9) == 0) ? SECONDS_W'($urandom_range(1, 65535))
                                         : SECONDS_W'($urandom_range(1, 8));
    span   = 64'(secs) * NS_PER_S;
    inner  = $urandom_range(0, 6);
    start  = now_ns + 64'($urandom_range(1, 5000));
    stride = span / 64'(inner + 1);
    send_arm(secs);
    send_frame(start);
    for (int k = 1; k <= inner; k++) begin
      stamp = start + stride * 64'(k) + rand64() % (stride / 2 + 1);
      // now and then retarget the request while the window is open
      if ($urandom_range(0, 19) == 0) send_arm(SECONDS_W'($urandom));
      send_frame(stamp);
    end
    case ($urandom_range(0, 3))
      0: stamp = start + span;
      1: begin
        send_frame(start + span - 1);
        stamp = start + span + 64'($urandom_range(0, 1000));
      end
      default: stamp = start + span + 64'($urandom_range(0, 1000000));
    endcase
    send_frame(stamp);
    now_ns = stamp;
  endtask

  // Frames outside any plan: random, forward, backward, near wrap, zero.
  task automatic stray_frames();
    logic [TIME_W-1:0] stamp;
    int                count;
    count = $urandom_range(1, 3);
    repeat (count) begin
      case ($urandom_range(0, 4))
        0: stamp = rand64();
        1: stamp = now_ns + 64'($urandom_range(0, 1000000));
        2: stamp = now_ns - 64'($urandom_range(0, 1000000));
        3: stamp = 64'hFFFF_FFFF_FFFF_FFFF - 64'($urandom_range(0, 2000000000));
        default: stamp = '0;
      endcase
      send_frame(stamp);
      now_ns = stamp;
    end
  endtask

  // Window that is withdrawn, retargeted or simply left open.
  task automatic broken_window();
    logic [TIME_W-1:0] start;
    logic [TIME_W-1:0] stamp;
    send_arm(SECONDS_W'($urandom_range(1, 20)));
    start = now_ns + 64'($urandom_range(1, 5000));
    send_frame(start);
    stamp = start + 64'($urandom_range(0, 1000000));
    send_frame(stamp);
    case ($urandom_range(0, 2))
      0: begin
        send_arm('0);
        stamp = stamp + 64'($urandom_range(0, 1000));
        send_frame(stamp);
      end
      1: send_arm(SECONDS_W'($urandom_range(1, 20)));
      default: ;
    endcase
    now_ns = stamp;
  endtask

  // Sample both channels at the edge; feed the scoreboard and the watchdog.
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall) tracker.take_item(action, timestamp_ns, window_seconds);
      if (out_valid && !out_stall)
        tracker.match_report(frames_per_second_milli, shortest_interval_ns,
                             longest_interval_ns, frames_in_window);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles = 0;
      else quiet_cycles++;
    end
  end

  initial begin
    while (quiet_cycles < QUIET_LIMIT) @(posedge clk);
    $display("tb_frame_interval_window_monitor: errors");
    $finish;
  end

  // Receiver: random stall before each report; twice, hold off for a long
  // stretch so the output register fills and the block stalls its input.
  initial begin
    int hold;
    int taken;
    taken = 0;
    out_stall <= 1'b0;
    forever begin
      hold = steady ? 0 : $urandom_range(0, 4);
      if (taken == 10 || taken == 100) hold = LONG_HOLD;
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
        out_stall <= 1'b0;
      end
      do @(posedge clk); while (!out_valid || rst);
      taken++;
    end
  end

  initial begin
    int pick;
    tracker        = new();
    items_sent     = 0;
    quiet_cycles   = 0;
    steady         = 1'b0;
    now_ns         = 64'd1000;
    rst            <= 1'b1;
    in_valid       <= 1'b0;
    action         <= ACT_FRAME;
    timestamp_ns   <= '0;
    window_seconds <= '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // frame at time zero leaves the window closed; the next frame opens it
    send_arm(16'd1);
    send_frame(64'd0);
    send_frame(64'd5);
    send_frame(64'd1000000005);
    // withdraw while open, then a frame at the opening stamp: zero elapsed
    send_arm(16'd3);
    send_frame(64'd100);
    send_arm(16'd0);
    send_frame(64'd100);
    // window across the wrap of the timestamp
    send_arm(16'd1);
    send_frame(64'hFFFF_FFFF_E23B_4C80);
    send_frame(64'hFFFF_FFFF_FFFF_FFFF);
    send_frame(64'd600000000);
    // timestamp going backwards gives a huge interval and ends the window
    send_arm(16'd2);
    send_frame(64'd1000);
    send_frame(64'd500);
    // largest request, shrunk while open; miss by one ns, then hit exactly
    send_arm(16'hFFFF);
    send_frame(64'd10);
    send_arm(16'd1);
    send_frame(64'd1000000009);
    send_frame(64'd1000000010);
    // open at all ones, wrap to zero, then withdraw: tiny elapsed saturates rate
    send_arm(16'hFFFF);
    send_frame(64'hFFFF_FFFF_FFFF_FFFF);
    send_frame(64'd0);
    send_arm(16'd0);
    send_frame(64'd3);

    // random part: mostly well-formed windows, the rest noise
    while (items_sent < TOTAL_ITEMS) begin
      if ($urandom_range(0, 15) == 0) steady = !steady;
      pick = $urandom_range(0, 99);
      if (pick < 70) run_window();
      else if (pick < 82) stray_frames();
      else if (pick < 90) send_arm(SECONDS_W'($urandom));
      else broken_window();
    end
    in_valid <= 1'b0;

    // drain owed reports, then give the block time to show anything extra
    while (tracker.outstanding() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (tracker.errors == 0 && tracker.outstanding() == 0) begin
      $display("tb_frame_interval_window_monitor: clean");
    end else begin
      $display("tb_frame_interval_window_monitor: errors");
    end
    $finish;
  end

endmodule
`default_nettype wire
